// ===== rtl/core/fspc_pkg.sv =====
// Shared types and constants for the five stage pipeline core.
package fspc_pkg;

  // Instruction opcodes
  typedef enum logic [2:0] {
    OP_NOP   = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_LOAD  = 3'd3,
    OP_STORE = 3'd4,
    OP_BR    = 3'd5,
    OP_BREQ  = 3'd6,
    OP_BRNEQ = 3'd7
  } op_e;

  // One decoded instruction as it moves down the pipe
  typedef struct packed {
    op_e         op;
    logic [4:0]  src1;
    logic [31:0] src2;
    logic        imm;
    logic [4:0]  dst;
  } cmd_t;

  // One stage register: instruction, its pc and its three operand values
  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] pc;
    logic [31:0] v1;
    logic [31:0] v2;
    logic [31:0] vd;
  } stage_t;

  // Stage positions in the stage and snapshot arrays
  localparam int unsigned ST_IF  = 0;
  localparam int unsigned ST_ID  = 1;
  localparam int unsigned ST_EX  = 2;
  localparam int unsigned ST_MEM = 3;
  localparam int unsigned NUM_ST = 4;

  localparam int unsigned IN_W  = 80;
  localparam int unsigned OUT_W = 168;

  localparam logic [31:0] PC_STEP = 32'd4;

  // Opcodes that write the register file
  function automatic logic writes_reg(op_e op);
    return (op == OP_ADD) || (op == OP_SUB) || (op == OP_LOAD);
  endfunction

endpackage

// ===== rtl/core/five_stage_pipeline_core.sv =====
// Five stage in-order core: stage registers, forwarding, stall and branch logic.
//
// Usage: each transfer on the slave stream is one clock tick of the core. It
// carries the instruction at the fetch address announced by the previous
// result, plus load data and a wait flag for the announced load. Each accepted
// item yields exactly one result on the master stream: next fetch address,
// next load request and address, this tick's store and register write.
// The result is registered and shown in the cycle after the input transfer.
// Throughput: one item per cycle; the whole tick is computed by one pass of
// logic from the stage registers to the result register.
// The slave side stays ready while the result register is empty or is being
// taken in the same cycle; when the receiver stalls, the result holds and the
// next input waits.
// Reset clears the register file, all stage and snapshot registers, the pc
// and the branch target; the first tick after reset only places the fetched
// instruction and announces address 4.
// Forwarding comes from MEM and WB into EX; a load followed by a user stalls
// one tick; a taken branch resolves in MEM and flushes three stages.
module five_stage_pipeline_core #(
  parameter int unsigned REG_COUNT = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // instr_opcode[2:0], instr_src1[7:3], instr_src2[39:8], instr_src2_is_imm[40],
  // instr_dst[45:41], load_data[77:46], load_wait[78], zero[79]
  input  logic [fspc_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // fetch_address[31:0], load_request[32], load_address[64:33], store_enable[65],
  // store_address[97:66], store_data[129:98], reg_write_enable[130],
  // reg_write_index[135:131], reg_write_value[167:136]
  output logic [fspc_pkg::OUT_W-1:0] m_axis_tdata
);
  import fspc_pkg::*;

  localparam int unsigned IW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  logic [31:0]  rf_q [REG_COUNT];
  stage_t       stg_q [NUM_ST];
  stage_t       snp_q [NUM_ST];
  logic [31:0]  pc_q, pc_d;
  logic [31:0]  bt_q, bt_d;
  logic         ar_q, ar_d;
  logic         wait_q, wait_d;
  logic         br_q, br_d;
  logic         stall_q, stall_d;
  stage_t       stg_d [NUM_ST];
  stage_t       snp_d [NUM_ST];
  logic         rf_we;
  logic [IW-1:0] rf_wi;
  logic [31:0]  rf_wv;
  logic         out_valid_q;
  logic [OUT_W-1:0] out_q, out_d;
  logic         in_xfer;

  // Register read; out of range reads zero
  function automatic logic [31:0] rd_pre(logic [31:0] idx);
    if (idx < REG_COUNT) return rf_q[idx[IW-1:0]];
    return 32'd0;
  endfunction

  // Register read that sees this tick's writeback
  function automatic logic [31:0] rd_post(logic [31:0] idx, logic we, logic [IW-1:0] wi,
                                          logic [31:0] wv);
    if (!(idx < REG_COUNT)) return 32'd0;
    if (we && (wi == idx[IW-1:0])) return wv;
    return rf_q[idx[IW-1:0]];
  endfunction

  // Forward one older result into the execute stage
  function automatic stage_t fwd(stage_t e, stage_t f);
    stage_t r;
    r = e;
    if (writes_reg(f.cmd.op)) begin
      if (f.cmd.dst == e.cmd.src1) r.v1 = f.vd;
      if (!e.cmd.imm && ({27'd0, f.cmd.dst} == e.cmd.src2)) r.v2 = f.vd;
      if ((e.cmd.op == OP_BR || e.cmd.op == OP_BREQ || e.cmd.op == OP_BRNEQ ||
           e.cmd.op == OP_STORE) && (e.cmd.dst == f.cmd.dst)) r.vd = f.vd;
    end
    return r;
  endfunction

  // Flush a stage, keeping its pc
  function automatic stage_t clr(stage_t s);
    stage_t r;
    r     = '0;
    r.pc  = s.pc;
    return r;
  endfunction

  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // Compute one full core tick
  always_comb begin
    logic        take;
    logic        lreq;
    logic [31:0] laddr;
    logic        se;
    logic [31:0] saddr, sdata;
    logic [4:0]  widx;
    logic [31:0] a, b;
    stage_t      f;
    stage_t      w;

    stg_d   = stg_q;
    snp_d   = snp_q;
    pc_d    = pc_q;
    bt_d    = bt_q;
    ar_d    = ar_q;
    wait_d  = wait_q;
    br_d    = br_q;
    stall_d = stall_q;
    take    = 1'b0;
    lreq    = 1'b0;
    laddr   = '0;
    se      = 1'b0;
    saddr   = '0;
    sdata   = '0;
    widx    = '0;
    rf_we   = 1'b0;
    rf_wi   = '0;
    rf_wv   = '0;
    a       = '0;
    b       = '0;

    // Placed instruction from the input transfer
    f          = '0;
    f.cmd.op   = op_e'(s_axis_tdata[2:0]);
    f.cmd.src1 = s_axis_tdata[7:3];
    f.cmd.src2 = s_axis_tdata[39:8];
    f.cmd.imm  = s_axis_tdata[40];
    f.cmd.dst  = s_axis_tdata[45:41];

    if (wait_q) begin
      // Replay memory and writeback
      wait_d = 1'b0;
    end else begin
      for (int s = 0; s < NUM_ST; s++) snp_d[s] = stg_q[s];
      if (stall_q && !br_q) begin
        stg_d[ST_EX] = clr(stg_q[ST_EX]);
        stall_d      = 1'b0;
      end else begin
        stall_d = 1'b0;
        if (ar_q) begin
          ar_d          = 1'b0;
          f.pc          = pc_q;
          stg_d[ST_IF]  = f;
        end else begin
          // Fetch: redirect on a pending branch
          if (br_q) begin
            stg_d[ST_IF] = clr(stg_q[ST_IF]);
            stg_d[ST_ID] = clr(stg_q[ST_ID]);
            stg_d[ST_EX] = clr(stg_q[ST_EX]);
            snp_d[ST_IF] = stg_d[ST_IF];
            snp_d[ST_ID] = stg_d[ST_ID];
            snp_d[ST_EX] = stg_d[ST_EX];
            br_d         = 1'b0;
            pc_d         = bt_q;
          end else begin
            pc_d = pc_q + PC_STEP;
          end
          f.pc         = pc_d;
          stg_d[ST_IF] = f;

          // Decode: read operands
          stg_d[ST_ID]    = snp_d[ST_IF];
          stg_d[ST_ID].v1 = rd_pre({27'd0, stg_d[ST_ID].cmd.src1});
          if (stg_d[ST_ID].cmd.imm && stg_d[ST_ID].cmd.op != OP_NOP &&
              stg_d[ST_ID].cmd.op != OP_BR)
            stg_d[ST_ID].v2 = stg_d[ST_ID].cmd.src2;
          else
            stg_d[ST_ID].v2 = rd_pre(stg_d[ST_ID].cmd.src2);
          stg_d[ST_ID].vd = rd_pre({27'd0, stg_d[ST_ID].cmd.dst});

          // Execute: load-use check, forward, ALU
          stg_d[ST_EX] = snp_d[ST_ID];
          if (stg_d[ST_EX].cmd.op == OP_LOAD &&
              (stg_d[ST_EX].cmd.dst == stg_d[ST_ID].cmd.src1 ||
               (!stg_d[ST_ID].cmd.imm &&
                {27'd0, stg_d[ST_EX].cmd.dst} == stg_d[ST_ID].cmd.src2)))
            stall_d = 1'b1;
          stg_d[ST_EX] = fwd(stg_d[ST_EX], snp_d[ST_MEM]);
          stg_d[ST_EX] = fwd(stg_d[ST_EX], snp_d[ST_EX]);
          a = stg_d[ST_EX].v1;
          b = stg_d[ST_EX].v2;
          if (stg_d[ST_EX].cmd.op == OP_SUB)
            stg_d[ST_EX].vd = a - b;
          else if (stg_d[ST_EX].cmd.op == OP_ADD || stg_d[ST_EX].cmd.op == OP_LOAD)
            stg_d[ST_EX].vd = a + b;
        end
      end
    end

    // Memory stage
    stg_d[ST_MEM] = snp_d[ST_EX];
    case (stg_d[ST_MEM].cmd.op)
      OP_BR:    take = 1'b1;
      OP_BREQ:  take = (stg_d[ST_MEM].v1 == stg_d[ST_MEM].v2);
      OP_BRNEQ: take = (stg_d[ST_MEM].v1 != stg_d[ST_MEM].v2);
      OP_LOAD: begin
        if (s_axis_tdata[78]) wait_d = 1'b1;
        else stg_d[ST_MEM].vd = s_axis_tdata[77:46];
      end
      OP_STORE: begin
        se    = 1'b1;
        saddr = stg_d[ST_MEM].vd + stg_d[ST_MEM].v2;
        sdata = stg_d[ST_MEM].v1;
      end
      default: take = 1'b0;
    endcase
    if (take) begin
      br_d = 1'b1;
      bt_d = stg_d[ST_MEM].vd + stg_d[ST_MEM].pc + PC_STEP;
    end

    // Writeback stage
    w = snp_d[ST_MEM];
    if (writes_reg(w.cmd.op) && ({27'd0, w.cmd.dst} < REG_COUNT)) begin
      rf_we = 1'b1;
      rf_wi = IW'({27'd0, w.cmd.dst});
      rf_wv = w.vd;
      widx  = w.cmd.dst;
    end
    stg_d[ST_ID].vd = rd_post({27'd0, stg_d[ST_ID].cmd.dst}, rf_we, rf_wi, rf_wv);
    stg_d[ST_ID].v1 = rd_post({27'd0, stg_d[ST_ID].cmd.src1}, rf_we, rf_wi, rf_wv);
    if (!stg_d[ST_ID].cmd.imm)
      stg_d[ST_ID].v2 = rd_post(stg_d[ST_ID].cmd.src2, rf_we, rf_wi, rf_wv);

    // Announce next load
    if (wait_d) begin
      lreq  = (snp_d[ST_EX].cmd.op == OP_LOAD);
      laddr = lreq ? snp_d[ST_EX].vd : 32'd0;
    end else if (!br_d) begin
      lreq  = (stg_d[ST_EX].cmd.op == OP_LOAD);
      laddr = lreq ? stg_d[ST_EX].vd : 32'd0;
    end

    out_d = {(rf_we ? rf_wv : 32'd0), widx, rf_we, sdata, saddr, se, laddr, lreq,
             (br_d ? bt_d : pc_d + PC_STEP)};
  end

  // Advance core state on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_COUNT; i++) rf_q[i] <= '0;
      for (int s = 0; s < NUM_ST; s++) begin
        stg_q[s] <= '0;
        snp_q[s] <= '0;
      end
      pc_q    <= '0;
      bt_q    <= '0;
      ar_q    <= 1'b1;
      wait_q  <= 1'b0;
      br_q    <= 1'b0;
      stall_q <= 1'b0;
    end else if (in_xfer) begin
      if (rf_we) rf_q[rf_wi] <= rf_wv;
      for (int s = 0; s < NUM_ST; s++) begin
        stg_q[s] <= stg_d[s];
        snp_q[s] <= snp_d[s];
      end
      pc_q    <= pc_d;
      bt_q    <= bt_d;
      ar_q    <= ar_d;
      wait_q  <= wait_d;
      br_q    <= br_d;
      stall_q <= stall_d;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) out_q <= out_d;
  end

  // A load wait and a pending branch never coexist
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(wait_q && br_q))
    else $error("load wait with pending branch");

  // Every input transfer produces a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_xfer |=> out_valid_q)
    else $error("missing result after transfer");

  // The after-reset tick happens once
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_xfer |=> !ar_q)
    else $error("after-reset flag still set");

  // Store fields stay zero without a store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q[65]) |-> (out_q[129:66] == '0))
    else $error("store fields set without store");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the five stage pipeline core, predictor included.
`timescale 1ns / 1ps

module tb_top;
  import fspc_pkg::*;

  localparam int unsigned ST_WB = 4;
  localparam int unsigned WATCH_LIMIT = 5000;
  localparam int unsigned LONG_HOLD = 300;

  // One predicted result of a core tick
  typedef struct {
    logic [31:0] fetch_addr;
    logic        ld_req;
    logic [31:0] ld_addr;
    logic        st_en;
    logic [31:0] st_addr;
    logic [31:0] st_data;
    logic        wr_en;
    logic [4:0]  wr_idx;
    logic [31:0] wr_val;
  } tick_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  five_stage_pipeline_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  // Predicted core state
  logic [31:0] regs_q [32];
  stage_t      pipe_q [5];
  stage_t      shadow_q [5];
  logic [31:0] pc_q, target_q;
  logic        after_rst_f, wait_f, branch_f, stall_f;

  tick_out_t   ticks_pending [$];
  int unsigned fail_cnt = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_req = 0;
  bit          no_gaps = 0;
  int          burst_left = 0;

  function automatic logic [31:0] reg_read(logic [31:0] idx);
    return (idx < 32) ? regs_q[idx[4:0]] : 32'd0;
  endfunction

  function automatic logic is_writer(op_e op);
    return op == OP_ADD || op == OP_SUB || op == OP_LOAD;
  endfunction

  function automatic void wipe_stage(int s);
    pipe_q[s].cmd = '0;
    pipe_q[s].v1 = '0;
    pipe_q[s].v2 = '0;
    pipe_q[s].vd = '0;
  endfunction

  function automatic void place_instr(cmd_t c);
    pipe_q[ST_IF].cmd = c;
    pipe_q[ST_IF].pc = pc_q;
    pipe_q[ST_IF].v1 = '0;
    pipe_q[ST_IF].v2 = '0;
    pipe_q[ST_IF].vd = '0;
  endfunction

  function automatic void forward_into_ex(int from);
    cmd_t e, f;
    logic [31:0] v;
    e = pipe_q[ST_EX].cmd;
    f = shadow_q[from].cmd;
    v = shadow_q[from].vd;
    if (!is_writer(f.op)) return;
    if (f.dst == e.src1) pipe_q[ST_EX].v1 = v;
    if (!e.imm && {27'd0, f.dst} == e.src2) pipe_q[ST_EX].v2 = v;
    if ((e.op == OP_BR || e.op == OP_BREQ || e.op == OP_BRNEQ || e.op == OP_STORE)
        && e.dst == f.dst) pipe_q[ST_EX].vd = v;
  endfunction

  function automatic void run_mem(logic [31:0] ld_data, logic ld_wait, ref tick_out_t o);
    logic take;
    take = 1'b0;
    pipe_q[ST_MEM] = shadow_q[ST_EX];
    case (pipe_q[ST_MEM].cmd.op)
      OP_BR: take = 1'b1;
      OP_BREQ: take = pipe_q[ST_MEM].v1 == pipe_q[ST_MEM].v2;
      OP_BRNEQ: take = pipe_q[ST_MEM].v1 != pipe_q[ST_MEM].v2;
      OP_LOAD: begin
        if (ld_wait) wait_f = 1'b1;
        else pipe_q[ST_MEM].vd = ld_data;
      end
      OP_STORE: begin
        o.st_en = 1'b1;
        o.st_addr = pipe_q[ST_MEM].vd + pipe_q[ST_MEM].v2;
        o.st_data = pipe_q[ST_MEM].v1;
      end
      default: ;
    endcase
    if (take) begin
      branch_f = 1'b1;
      target_q = pipe_q[ST_MEM].vd + pipe_q[ST_MEM].pc + PC_STEP;
    end
  endfunction

  function automatic void run_wb(ref tick_out_t o);
    cmd_t d;
    pipe_q[ST_WB] = shadow_q[ST_MEM];
    if (is_writer(pipe_q[ST_WB].cmd.op)) begin
      regs_q[pipe_q[ST_WB].cmd.dst] = pipe_q[ST_WB].vd;
      o.wr_en = 1'b1;
      o.wr_idx = pipe_q[ST_WB].cmd.dst;
      o.wr_val = pipe_q[ST_WB].vd;
    end
    // Refresh decode operands after the write
    d = pipe_q[ST_ID].cmd;
    pipe_q[ST_ID].vd = reg_read({27'd0, d.dst});
    pipe_q[ST_ID].v1 = reg_read({27'd0, d.src1});
    if (!d.imm) pipe_q[ST_ID].v2 = reg_read(d.src2);
  endfunction

  // Advance the predicted core by one tick and return its result
  function automatic tick_out_t predict_tick(cmd_t c, logic [31:0] ld_data, logic ld_wait);
    tick_out_t o;
    cmd_t d, e;
    stage_t nx;
    o = '{default: '0};
    if (wait_f) begin
      wait_f = 1'b0;
      run_wb(o);
      run_mem(ld_data, ld_wait, o);
      wipe_stage(ST_WB);
    end else begin
      for (int s = 0; s < 5; s++) shadow_q[s] = pipe_q[s];
      if (stall_f && !branch_f) begin
        wipe_stage(ST_EX);
        stall_f = 1'b0;
      end else begin
        stall_f = 1'b0;
        if (after_rst_f) begin
          after_rst_f = 1'b0;
          place_instr(c);
        end else begin
          // fetch
          if (branch_f) begin
            for (int s = ST_IF; s <= ST_EX; s++) begin
              wipe_stage(s);
              shadow_q[s] = pipe_q[s];
            end
            branch_f = 1'b0;
            pc_q = target_q;
          end else begin
            pc_q = pc_q + PC_STEP;
          end
          place_instr(c);
          // decode
          pipe_q[ST_ID] = shadow_q[ST_IF];
          d = pipe_q[ST_ID].cmd;
          pipe_q[ST_ID].v1 = reg_read({27'd0, d.src1});
          if (d.imm && d.op != OP_NOP && d.op != OP_BR) pipe_q[ST_ID].v2 = d.src2;
          else pipe_q[ST_ID].v2 = reg_read(d.src2);
          pipe_q[ST_ID].vd = reg_read({27'd0, d.dst});
          // execute
          pipe_q[ST_EX] = shadow_q[ST_ID];
          e = pipe_q[ST_EX].cmd;
          if (e.op == OP_LOAD && (e.dst == d.src1 || (!d.imm && {27'd0, e.dst} == d.src2)))
            stall_f = 1'b1;
          forward_into_ex(ST_MEM);
          forward_into_ex(ST_EX);
          if (e.op == OP_SUB) pipe_q[ST_EX].vd = pipe_q[ST_EX].v1 - pipe_q[ST_EX].v2;
          else if (e.op == OP_ADD || e.op == OP_LOAD)
            pipe_q[ST_EX].vd = pipe_q[ST_EX].v1 + pipe_q[ST_EX].v2;
        end
      end
      run_mem(ld_data, ld_wait, o);
      run_wb(o);
    end
    o.fetch_addr = branch_f ? target_q : pc_q + PC_STEP;
    nx = '0;
    if (wait_f) nx = shadow_q[ST_EX];
    else if (!branch_f) nx = pipe_q[ST_EX];
    if (nx.cmd.op == OP_LOAD) begin
      o.ld_req = 1'b1;
      o.ld_addr = nx.vd;
    end
    return o;
  endfunction

  // Offer one tick to the core; bursts with random gaps between them
  task automatic send_tick(op_e op, logic [4:0] s1, logic [31:0] s2, logic imm,
                           logic [4:0] dst, logic [31:0] ld_data, logic ld_wait);
    cmd_t c;
    c.op = op; c.src1 = s1; c.src2 = s2; c.imm = imm; c.dst = dst;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, ld_wait, ld_data, dst, imm, s2, s1, op};
    do @(posedge clk_i); while (!s_axis_tready);
    ticks_pending.push_back(predict_tick(c, ld_data, ld_wait));
    if (!no_gaps) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(0, 15);
      end
    end
  endtask

  task automatic send_random_tick();
    op_e op;
    logic [31:0] s2;
    logic imm;
    op = op_e'($urandom_range(0, 7));
    imm = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0: s2 = $urandom();
      1: s2 = $urandom_range(0, 40);
      default: s2 = imm ? $urandom_range(0, 64) - 32 : $urandom_range(0, 7);
    endcase
    send_tick(op, 5'($urandom_range(0, 7)), s2, imm,
              ($urandom_range(0, 4) == 0) ? 5'($urandom()) : 5'($urandom_range(0, 7)),
              $urandom(), $urandom_range(0, 3) == 0);
  endtask

  task automatic test_directed();
    send_tick(OP_ADD, 5'd0, 32'h7fff_ffff, 1'b1, 5'd1, 32'd0, 1'b0);
    send_tick(OP_ADD, 5'd0, 32'h8000_0000, 1'b1, 5'd2, 32'd0, 1'b0);
    send_tick(OP_ADD, 5'd1, 32'd2, 1'b0, 5'd3, 32'd0, 1'b0);
    send_tick(OP_SUB, 5'd3, 32'd1, 1'b0, 5'd31, 32'd0, 1'b0);
    send_tick(OP_SUB, 5'd31, 32'hffff_ffff, 1'b1, 5'd4, 32'd0, 1'b0);
    // load then immediate user: stall
    send_tick(OP_LOAD, 5'd1, 32'd4, 1'b1, 5'd5, 32'd0, 1'b0);
    send_tick(OP_ADD, 5'd5, 32'd5, 1'b0, 5'd6, 32'd0, 1'b0);
    send_tick(OP_NOP, 5'd0, 32'd0, 1'b0, 5'd0, 32'h8000_0000, 1'b1);
    send_tick(OP_NOP, 5'd0, 32'd0, 1'b0, 5'd0, 32'h8000_0000, 1'b1);
    send_tick(OP_NOP, 5'd0, 32'd0, 1'b0, 5'd0, 32'h7fff_ffff, 1'b0);
    send_tick(OP_STORE, 5'd6, 32'd16, 1'b1, 5'd2, 32'hffff_ffff, 1'b0);
    send_tick(OP_STORE, 5'd31, 32'd100, 1'b0, 5'd31, 32'd0, 1'b0);
    send_tick(OP_BREQ, 5'd0, 32'd0, 1'b1, 5'd0, 32'd0, 1'b0);
    send_tick(OP_BRNEQ, 5'd1, 32'd2, 1'b0, 5'd0, 32'd0, 1'b0);
    send_tick(OP_BR, 5'd0, 32'hffff_ffff, 1'b1, 5'd2, 32'd0, 1'b0);
    for (int i = 0; i < 6; i++)
      send_tick(OP_NOP, 5'd31, 32'hffff_ffff, 1'b1, 5'd31, 32'hffff_ffff, 1'b0);
    send_tick(OP_ADD, 5'd31, 32'hffff_ffff, 1'b0, 5'd7, 32'd0, 1'b0);
    send_tick(OP_LOAD, 5'd31, 32'h8000_0000, 1'b1, 5'd8, 32'd0, 1'b0);
    send_tick(OP_STORE, 5'd8, 32'd8, 1'b0, 5'd8, 32'h1234_5678, 1'b0);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_random_tick();
  endtask

  // Hold the receiver off while the sender keeps offering
  task automatic test_backpressure();
    no_gaps = 1;
    hold_req++;
    test_random(60);
    no_gaps = 0;
  endtask

  // Receiver readiness: changing patterns plus a requested long hold-off
  initial begin
    int unsigned mode, hold_seen, hold_left;
    mode = 0; hold_seen = 0; hold_left = 0;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= $urandom_range(0, 3) == 0;
          default: m_axis_tready <= $urandom_range(0, 7) != 0;
        endcase
      end
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    tick_out_t x, a;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      {a.wr_val, a.wr_idx, a.wr_en, a.st_data, a.st_addr, a.st_en,
       a.ld_addr, a.ld_req, a.fetch_addr} = m_axis_tdata;
      if (ticks_pending.size() == 0) begin
        $error("result with no tick pending");
        fail_cnt++;
      end else begin
        x = ticks_pending.pop_front();
        if (a.fetch_addr !== x.fetch_addr) begin
          $error("fetch_address exp %h got %h", x.fetch_addr, a.fetch_addr); fail_cnt++;
        end
        if (a.ld_req !== x.ld_req) begin
          $error("load_request exp %h got %h", x.ld_req, a.ld_req); fail_cnt++;
        end
        if (a.ld_addr !== x.ld_addr) begin
          $error("load_address exp %h got %h", x.ld_addr, a.ld_addr); fail_cnt++;
        end
        if (a.st_en !== x.st_en) begin
          $error("store_enable exp %h got %h", x.st_en, a.st_en); fail_cnt++;
        end
        if (a.st_addr !== x.st_addr) begin
          $error("store_address exp %h got %h", x.st_addr, a.st_addr); fail_cnt++;
        end
        if (a.st_data !== x.st_data) begin
          $error("store_data exp %h got %h", x.st_data, a.st_data); fail_cnt++;
        end
        if (a.wr_en !== x.wr_en) begin
          $error("reg_write_enable exp %h got %h", x.wr_en, a.wr_en); fail_cnt++;
        end
        if (a.wr_idx !== x.wr_idx) begin
          $error("reg_write_index exp %h got %h", x.wr_idx, a.wr_idx); fail_cnt++;
        end
        if (a.wr_val !== x.wr_val) begin
          $error("reg_write_value exp %h got %h", x.wr_val, a.wr_val); fail_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 32; i++) regs_q[i] = '0;
    for (int s = 0; s < 5; s++) begin
      pipe_q[s] = '0;
      shadow_q[s] = '0;
    end
    pc_q = '0; target_q = '0;
    after_rst_f = 1'b1; wait_f = 1'b0; branch_f = 1'b0; stall_f = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(400);
    test_backpressure();
    test_random(370);
    s_axis_tvalid <= 1'b0;
    while (ticks_pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
